### sv/fpr_pkg.sv
package fpr_pkg;

  // Result status codes carried in the low bits of m_tuser.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC    = 2'd0;
  localparam logic [1:0] CFG_OWN     = 2'd1;
  localparam logic [1:0] CFG_BCAST   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Input kinds carried on s_tuser.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 3;
  localparam int ELAPSED_W   = 17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       frame_clear;
    logic       ld_sender;
    logic       ld_target;
    logic       ld_command;
    logic       ld_length;
    logic       wr_payload;
    logic       ld_check_hi;
    logic       ld_check_lo;
    logic       tick;
    logic       burst_start;
    logic       burst_step;
    logic       out_load;
    logic [1:0] out_status;
  } fpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sync_hit;
    logic over_now;
    logic over_tick;
    logic len_over;
    logic len_zero;
    logic data_done;
    logic target_hit;
    logic length_zero;
    logic burst_last;
    logic out_free;
  } fpr_stat_t;

endpackage

### sv/fpr_datapath.sv
module fpr_datapath #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [fpr_pkg::IN_TDATA_W-1:0]    rx_byte,
  input  fpr_pkg::fpr_cmd_t                 cmd,
  output fpr_pkg::fpr_stat_t                stat,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [fpr_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic [fpr_pkg::OUT_TUSER_W-1:0]   m_tuser,
  output logic                              m_tlast
);
  import fpr_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]           sync_value;
  logic [7:0]           own_address;
  logic [7:0]           broadcast_address;
  logic [15:0]          timeout_ticks;

  logic [7:0]           sender;
  logic [7:0]           target;
  logic [7:0]           command;
  logic [CW-1:0]        length;
  logic [CW-1:0]        count;
  logic [15:0]          check;
  logic [ELAPSED_W-1:0] elapsed;
  logic [AW-1:0]        burst_idx;
  logic [7:0]           rd_data;
  logic [7:0]           payload_mem [MAX_PAYLOAD];

  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [CW-1:0]        count_inc;
  logic [CW-1:0]        idx_inc_ext;
  logic [AW-1:0]        idx_inc;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [15:0]          check_next;
  logic [7:0]           len8;
  logic [7:0]           idx8;
  logic                 is_ok;

  logic [1:0]           o_status;
  logic [7:0]           o_sender;
  logic [7:0]           o_target;
  logic [7:0]           o_command;
  logic [5:0]           o_length;
  logic [4:0]           o_index;
  logic [7:0]           o_byte;
  logic                 o_valid;
  logic [15:0]          o_check;
  logic                 o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value        <= 8'd85;
      own_address       <= 8'd1;
      broadcast_address <= 8'd255;
      timeout_ticks     <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC:    sync_value        <= cfg_data[7:0];
        CFG_OWN:     own_address       <= cfg_data[7:0];
        CFG_BCAST:   broadcast_address <= cfg_data[7:0];
        CFG_TIMEOUT: timeout_ticks     <= cfg_data[15:0];
      endcase
    end
  end

  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + ELAPSED_W'(1);
  assign count_inc   = count + CW'(1);
  assign idx_inc_ext = CW'(burst_idx) + CW'(1);
  assign idx_inc     = burst_idx + AW'(1);
  assign check_next  = cmd.ld_check_lo ? {check[15:8], rx_byte} : check;

  always_comb begin
    stat.sync_hit    = (rx_byte == sync_value);
    stat.over_now    = (elapsed > {1'b0, timeout_ticks});
    stat.over_tick   = (elapsed_inc > {1'b0, timeout_ticks});
    stat.len_over    = ({1'b0, rx_byte} > 9'(MAX_PAYLOAD));
    stat.len_zero    = (rx_byte == 8'd0);
    stat.data_done   = (count_inc >= length);
    stat.target_hit  = (target == own_address) || (target == broadcast_address);
    stat.length_zero = (length == '0);
    stat.burst_last  = (idx_inc_ext == length);
    stat.out_free    = !m_tvalid || m_tready;
  end

  // Frame header, counters and check value.
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      count   <= '0;
    end else begin
      if (cmd.frame_clear) begin
        elapsed <= '0;
        count   <= '0;
      end else begin
        if (cmd.tick)       elapsed <= elapsed_inc;
        if (cmd.wr_payload) count   <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_sender)   sender  <= rx_byte;
    if (cmd.ld_target)   target  <= rx_byte;
    if (cmd.ld_command)  command <= rx_byte;
    if (cmd.ld_length)   length  <= CW'(rx_byte);
    if (cmd.ld_check_hi) check   <= {rx_byte, 8'd0};
    if (cmd.ld_check_lo) check   <= check_next;
  end

  // Payload RAM: written during the data phase, read once per burst beat.
  // The next entry is fetched as the current one moves into the output register.
  assign rd_en   = cmd.burst_start || (cmd.burst_step && !stat.burst_last);
  assign rd_addr = cmd.burst_start ? '0 : idx_inc;

  always_ff @(posedge clk) begin
    if (cmd.wr_payload) payload_mem[count[AW-1:0]] <= rx_byte;
    if (rd_en)          rd_data <= payload_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.burst_start) burst_idx <= '0;
    else if (cmd.burst_step) burst_idx <= idx_inc;
  end

  // Output register contents.
  assign len8  = 8'(length);
  assign idx8  = 8'(burst_idx);
  assign is_ok = (cmd.out_status == STATUS_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status  <= cmd.out_status;
      o_sender  <= is_ok ? sender : 8'd0;
      o_target  <= is_ok ? target : 8'd0;
      o_command <= is_ok ? command : 8'd0;
      o_length  <= is_ok ? len8[5:0] : 6'd0;
      o_check   <= is_ok ? check_next : 16'd0;
      o_index   <= cmd.burst_step ? idx8[4:0] : 5'd0;
      o_byte    <= cmd.burst_step ? rd_data : 8'd0;
      o_valid   <= cmd.burst_step;
      o_last    <= cmd.burst_step ? stat.burst_last : 1'b1;
    end
  end

  assign m_tdata = {5'd0, o_check, o_byte, o_index, o_length, o_command, o_target, o_sender};
  assign m_tuser = {o_valid, o_status};
  assign m_tlast = o_last;

endmodule

### sv/fpr_controller.sv
module fpr_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tuser,
  output logic               s_tready,
  input  fpr_pkg::fpr_stat_t stat,
  output fpr_pkg::fpr_cmd_t  cmd
);
  import fpr_pkg::*;

  typedef enum logic [3:0] {
    ST_SYNC,
    ST_SENDER,
    ST_TARGET,
    ST_COMMAND,
    ST_LENGTH,
    ST_DATA,
    ST_CHECK_HI,
    ST_CHECK_LO,
    ST_BURST
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state != ST_BURST) && stat.out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (state == ST_BURST) begin
      if (stat.out_free) begin
        cmd.burst_step = 1'b1;
        cmd.out_load   = 1'b1;
        cmd.out_status = STATUS_OK;
        if (stat.burst_last) state_next = ST_SYNC;
      end
    end else if (accept) begin
      if (s_tuser == REQ_TICK) begin
        if (state != ST_SYNC) begin
          cmd.tick = 1'b1;
          if (stat.over_tick) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = STATUS_TIMEOUT;
            state_next     = ST_SYNC;
          end
        end
      end else if (state != ST_SYNC && stat.over_now) begin
        // A lowered timeout is caught on the next byte and wins over the frame.
        cmd.out_load   = 1'b1;
        cmd.out_status = STATUS_TIMEOUT;
        state_next     = ST_SYNC;
      end else begin
        unique case (state)
          ST_SYNC: begin
            if (stat.sync_hit) begin
              cmd.frame_clear = 1'b1;
              state_next      = ST_SENDER;
            end
          end
          ST_SENDER: begin
            cmd.ld_sender = 1'b1;
            state_next    = ST_TARGET;
          end
          ST_TARGET: begin
            cmd.ld_target = 1'b1;
            state_next    = ST_COMMAND;
          end
          ST_COMMAND: begin
            cmd.ld_command = 1'b1;
            state_next     = ST_LENGTH;
          end
          ST_LENGTH: begin
            cmd.ld_length = 1'b1;
            if (stat.len_over) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = STATUS_OVERSIZE;
              state_next     = ST_SYNC;
            end else if (stat.len_zero) begin
              state_next = ST_CHECK_HI;
            end else begin
              state_next = ST_DATA;
            end
          end
          ST_DATA: begin
            cmd.wr_payload = 1'b1;
            if (stat.data_done) state_next = ST_CHECK_HI;
          end
          ST_CHECK_HI: begin
            cmd.ld_check_hi = 1'b1;
            state_next      = ST_CHECK_LO;
          end
          ST_CHECK_LO: begin
            cmd.ld_check_lo = 1'b1;
            state_next      = ST_SYNC;
            if (stat.target_hit) begin
              if (stat.length_zero) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = STATUS_OK;
              end else begin
                cmd.burst_start = 1'b1;
                state_next      = ST_BURST;
              end
            end
          end
          ST_BURST: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SYNC;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/framed_packet_receiver_top.sv
// Parses a serial stream of sync, sender, target, command, length, payload and a
// 16-bit check value (high byte first, passed on unverified), with millisecond
// ticks on the same input marked by s_tuser. One byte or tick is taken per cycle
// whenever the output register is free. A frame addressed to own_address or
// broadcast_address with a payload then occupies the block for a burst of one
// beat per payload byte, as the payload RAM delivers one entry per cycle through
// its single read port while m_tready does not stall a beat; an empty payload
// gives one beat with byte_valid low, loaded with the last check byte. The input
// is held off during a burst and whenever m_tready stalls a result. Timeouts and
// oversize lengths give a single beat with last set and all header fields zero.
module framed_packet_receiver_top #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fpr_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] rx_byte
  input  logic                              s_tuser,   // [0] req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] sender, [15:8] target, [23:16] command, [29:24] payload_length,
  // [34:30] payload_index, [42:35] payload_byte, [58:43] check_value, rest zero
  output logic [fpr_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic [fpr_pkg::OUT_TUSER_W-1:0]   m_tuser,   // [1:0] status, [2] byte_valid
  output logic                              m_tlast
);
  import fpr_pkg::*;

  fpr_cmd_t  cmd;
  fpr_stat_t stat;

  fpr_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fpr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // An input beat is only taken when its result has somewhere to go.
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
    else $error("input beat accepted while the output register was blocked");

  // Timeout and oversize results are always single beats.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] != STATUS_OK) |-> m_tlast)
    else $error("error result without last");

  // Payload bytes only come with accepted frames.
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == STATUS_OK))
    else $error("payload byte carried with an error status");

  // A burst beat without last is followed by a further beat of the same frame.
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser[2] && !m_tlast) |=> (m_tvalid && m_tuser[2]))
    else $error("payload burst broke off before its last beat");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fpr_pkg::*;

  localparam int MAX_PAYLOAD = 32;
  localparam int DRAIN_CYCLES = 2 * MAX_PAYLOAD + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_STALL = 400;
  localparam int IDLE_PCT = 22;
  localparam int FRAME_TICK_PCT = 8;

  typedef enum logic [2:0] {
    WAIT_SYNC,
    GET_SENDER,
    GET_TARGET,
    GET_COMMAND,
    GET_LENGTH,
    GET_PAYLOAD,
    GET_CHECK_HI,
    GET_CHECK_LO
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  sender;
    logic [7:0]  target;
    logic [7:0]  command;
    logic [5:0]  length;
    logic [4:0]  index;
    logic [7:0]  data;
    logic        valid;
    logic [15:0] check;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] data;
  } rx_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = REQ_BYTE;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tlast;

  // Register copies and parser state of the predictor.
  logic [7:0]   sync_cfg = 8'd85;
  logic [7:0]   own_cfg = 8'd1;
  logic [7:0]   bcast_cfg = 8'd255;
  logic [15:0]  timeout_cfg = 16'd100;
  parse_phase_e phase_q = WAIT_SYNC;
  logic [7:0]   sender_q = '0, target_q = '0, command_q = '0;
  logic [7:0]   length_q = '0, count_q = '0;
  logic [15:0]  check_q = '0;
  logic [16:0]  elapsed_q = '0;
  logic [7:0]   payload_mem [MAX_PAYLOAD];

  rx_item_t pending_items [$];
  beat_t    expected_beats [$];
  rx_item_t next_item;
  beat_t    got_beat, want_beat;
  int       items_queued = 0;
  int       items_accepted = 0;
  int       beats_seen = 0;
  int       mismatches = 0;
  int       stall_left = 0;
  logic     stall_request = 1'b0;
  logic     stall_done = 1'b0;
  int       quiet_cycles;

  always #1 clk = ~clk;

  framed_packet_receiver_top #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  function automatic void push_beat(logic [1:0] st, logic [4:0] idx, logic [7:0] data,
                                    logic vld, logic lst);
    beat_t b;
    b = '0;
    b.status = st;
    b.index = idx;
    b.data = data;
    b.valid = vld;
    b.last = lst;
    // Timeout and oversize beats carry no header.
    if (st == STATUS_OK) begin
      b.sender = sender_q;
      b.target = target_q;
      b.command = command_q;
      b.length = length_q[5:0];
      b.check = check_q;
    end
    expected_beats.push_back(b);
  endfunction

  function automatic void parse_rx_item(logic is_tick, logic [7:0] b);
    parse_phase_e prev;
    prev = phase_q;
    if (is_tick) begin
      if (phase_q != WAIT_SYNC) begin
        if (elapsed_q != '1) elapsed_q++;
        if (elapsed_q > {1'b0, timeout_cfg}) begin
          phase_q = WAIT_SYNC;
          push_beat(STATUS_TIMEOUT, '0, '0, 1'b0, 1'b1);
        end
      end
      return;
    end
    case (phase_q)
      WAIT_SYNC: begin
        if (b == sync_cfg) begin
          sender_q = '0;
          target_q = '0;
          command_q = '0;
          length_q = '0;
          count_q = '0;
          check_q = '0;
          elapsed_q = '0;
          phase_q = GET_SENDER;
        end
      end
      GET_SENDER: begin
        sender_q = b;
        phase_q = GET_TARGET;
      end
      GET_TARGET: begin
        target_q = b;
        phase_q = GET_COMMAND;
      end
      GET_COMMAND: begin
        command_q = b;
        phase_q = GET_LENGTH;
      end
      GET_LENGTH: begin
        length_q = b;
        phase_q = (b == 8'd0) ? GET_CHECK_HI : GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        if (count_q < MAX_PAYLOAD) payload_mem[count_q] = b;
        count_q++;
        if (count_q >= length_q) phase_q = GET_CHECK_HI;
      end
      GET_CHECK_HI: begin
        check_q = {b, 8'h00};
        phase_q = GET_CHECK_LO;
      end
      default: begin
        check_q = check_q + b;
        phase_q = WAIT_SYNC;
      end
    endcase
    // A timeout that was lowered mid-frame wins over every other outcome.
    if (prev != WAIT_SYNC && elapsed_q > {1'b0, timeout_cfg}) begin
      phase_q = WAIT_SYNC;
      push_beat(STATUS_TIMEOUT, '0, '0, 1'b0, 1'b1);
    end else if (prev == GET_LENGTH && length_q > MAX_PAYLOAD) begin
      phase_q = WAIT_SYNC;
      push_beat(STATUS_OVERSIZE, '0, '0, 1'b0, 1'b1);
    end else if (prev == GET_CHECK_LO && (target_q == own_cfg || target_q == bcast_cfg)) begin
      if (length_q == 8'd0) begin
        push_beat(STATUS_OK, '0, '0, 1'b0, 1'b1);
      end else begin
        for (int i = 0; i < length_q; i++)
          push_beat(STATUS_OK, i[4:0], payload_mem[i], 1'b1, (i + 1) == length_q);
      end
    end
  endfunction

  function automatic string beat_text(beat_t b);
    return $sformatf("st=%0d snd=%02h tgt=%02h cmd=%02h len=%0d idx=%0d byte=%02h vld=%0b %s",
                     b.status, b.sender, b.target, b.command, b.length, b.index, b.data,
                     b.valid, $sformatf("chk=%04h last=%0b", b.check, b.last));
  endfunction

  task automatic push_byte(logic [7:0] b);
    pending_items.push_back('{is_tick: 1'b0, data: b});
    items_queued++;
  endtask

  // The byte lane carries random junk on a tick; the block must ignore it.
  task automatic push_tick();
    pending_items.push_back('{is_tick: 1'b1, data: 8'($urandom)});
    items_queued++;
  endtask

  task automatic push_frame_byte(logic [7:0] b, int tick_pct);
    if ($urandom_range(99) < tick_pct) push_tick();
    push_byte(b);
  endtask

  task automatic queue_frame(logic [7:0] snd, logic [7:0] tgt, logic [7:0] cmd,
                             logic [7:0] len, logic [15:0] chk, int tick_pct);
    push_byte(sync_cfg);
    push_frame_byte(snd, tick_pct);
    push_frame_byte(tgt, tick_pct);
    push_frame_byte(cmd, tick_pct);
    push_frame_byte(len, tick_pct);
    if (len <= MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++) push_frame_byte(8'($urandom), tick_pct);
      push_frame_byte(chk[15:8], tick_pct);
      push_frame_byte(chk[7:0], tick_pct);
    end
  endtask

  task automatic queue_random_chunk();
    int pick;
    int len_pick;
    logic [7:0] tgt;
    logic [7:0] len;
    pick = $urandom_range(99);
    if (pick < 70) begin
      case ($urandom_range(3))
        0, 1: tgt = own_cfg;
        2: tgt = bcast_cfg;
        default: tgt = 8'($urandom);
      endcase
      len_pick = $urandom_range(99);
      if (len_pick < 80) len = 8'($urandom_range(6));
      else if (len_pick < 90) len = 8'($urandom_range(MAX_PAYLOAD, MAX_PAYLOAD - 1));
      else len = 8'($urandom_range(255, MAX_PAYLOAD + 1));
      queue_frame(8'($urandom), tgt, 8'($urandom), len, 16'($urandom), FRAME_TICK_PCT);
    end else if (pick < 85) begin
      // Truncated frame, then, when the timeout is below 40, enough ticks to run it out.
      push_byte(sync_cfg);
      repeat ($urandom_range(4, 1)) push_byte(8'($urandom));
      if (timeout_cfg < 40) repeat (int'(timeout_cfg) + 1) push_tick();
    end else begin
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(1) == 1) push_tick();
        else push_byte(8'($urandom));
      end
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SYNC: sync_cfg = val[7:0];
      CFG_OWN: own_cfg = val[7:0];
      CFG_BCAST: bcast_cfg = val[7:0];
      default: timeout_cfg = val;
    endcase
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (items_accepted != items_queued || expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: holds each beat until it is taken, idles at random between beats.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_rx_item(s_tuser == REQ_TICK, s_tdata);
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 &&
            ((items_accepted >= 60 && items_accepted < 100) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          next_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= next_item.is_tick ? REQ_TICK : REQ_BYTE;
          s_tdata <= next_item.data;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_beat = {m_tuser[1:0], m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                    m_tdata[29:24], m_tdata[34:30], m_tdata[42:35], m_tuser[2],
                    m_tdata[58:43], m_tlast};
        beats_seen++;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: %s", beat_text(got_beat));
        end else begin
          want_beat = expected_beats.pop_front();
          if (got_beat !== want_beat) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat %0d mismatch", beats_seen);
              $display("  expected %s", beat_text(want_beat));
              $display("  actual   %s", beat_text(got_beat));
            end
          end
        end
      end
      if (stall_request && !stall_done) begin
        stall_left = LONG_STALL;
        stall_done = 1'b1;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (beats_seen >= 30 && beats_seen < 70) || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [7:0]  new_sync, new_own, new_bcast;
    logic [15:0] new_timeout;
    int          phase_goal;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: stray tick and bytes, an empty frame, two oversize lengths.
    @(negedge clk);
    push_tick();
    push_byte(8'h00);
    push_byte(8'hAA);
    queue_frame(8'hFF, own_cfg, 8'h00, 8'd0, 16'hFF00, 0);
    queue_frame(8'h00, 8'hFF, 8'h07, 8'd33, 16'h0000, 0);
    queue_frame(8'h01, 8'h02, 8'h03, 8'd255, 16'h0000, 0);
    wait_drained();

    // Timeout on a tick, then a frame left open with two ticks elapsed.
    write_reg(CFG_TIMEOUT, 16'd2);
    @(negedge clk);
    push_byte(sync_cfg);
    push_byte(8'h05);
    repeat (3) push_tick();
    push_byte(sync_cfg);
    push_byte(8'h09);
    repeat (2) push_tick();
    wait_drained();

    // Lowering the timeout mid-frame makes the next byte time out.
    write_reg(CFG_TIMEOUT, 16'd0);
    @(negedge clk);
    push_byte(8'h01);

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      case (p)
        0: begin
          new_sync = 8'd85;
          new_own = 8'd1;
          new_bcast = 8'd255;
          new_timeout = 16'd12;
        end
        1: begin
          new_sync = 8'd0;
          new_own = 8'd0;
          new_bcast = 8'd0;
          new_timeout = 16'd0;
        end
        2: begin
          new_sync = 8'd255;
          new_own = 8'd255;
          new_bcast = 8'd128;
          new_timeout = 16'hFFFF;
        end
        default: begin
          new_sync = 8'($urandom);
          new_own = 8'($urandom);
          new_bcast = 8'($urandom);
          new_timeout = 16'($urandom_range(24, 1));
        end
      endcase
      // Upper data bits are junk for the byte-wide registers.
      write_reg(CFG_SYNC, {8'($urandom), new_sync});
      write_reg(CFG_OWN, {8'($urandom), new_own});
      write_reg(CFG_BCAST, {8'($urandom), new_bcast});
      write_reg(CFG_TIMEOUT, new_timeout);
      @(negedge clk);
      if (p == 2) begin
        // A full-size burst meets a long receiver stall, so the input backs up.
        stall_request <= 1'b1;
        queue_frame(8'($urandom), own_cfg, 8'($urandom), 8'(MAX_PAYLOAD), 16'($urandom), 0);
      end
      phase_goal = items_queued + 4;
      while (items_queued < phase_goal) queue_random_chunk();
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
